// ----- rtl/f16fr_pkg.sv -----
package f16fr_pkg;

    // Result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DATA    = 3'd1;
    localparam logic [2:0] EV_OK      = 3'd2;
    localparam logic [2:0] EV_BADSUM  = 3'd3;
    localparam logic [2:0] EV_TOOLONG = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MAGIC_WORD  = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ----- rtl/fletcher16_frame_receiver.sv -----
// Fletcher-16 frame receiver: takes one received byte per beat and deframes
// magic_hi, magic_lo, len_hi, len_lo, payload, check_hi, check_lo. Every input
// beat yields exactly one result beat (event code on m_tuser) in the cycle after
// acceptance, held in an output register. A new byte is accepted every cycle
// while the result side keeps up; throughput is one byte per cycle, set by the
// single parser step (mod-255 sums, position and compares) between the frame
// state registers and the output register. Configuration writes are taken in
// any cycle and apply from the next byte on.
module fletcher16_frame_receiver
    import f16fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] data_byte, [23:8] payload_index,
                                    // [39:24] frame_length
    output logic [2:0]  m_tuser,    // [2:0] event_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_result;
    logic    step;

    assign step = s_tvalid && s_tready;

    f16fr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    f16fr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (step_result)
    );

    f16fr_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .result_in  (step_result),
        .can_load   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (out_result)
    );

    assign m_tuser = out_result.event_res;
    assign m_tdata = {out_result.frame_length, out_result.payload_index, out_result.data_byte};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    a_non_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_DATA) |-> (m_tdata[23:0] == 24'd0))
        else $error("data byte or index set on non-payload event");

    a_index_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_DATA) |-> (m_tdata[23:8] < m_tdata[39:24]))
        else $error("payload index beyond frame length");

    a_quiet_events_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_NONE) |-> (m_tdata[39:24] == 16'd0))
        else $error("frame length reported without an event");
`endif

endmodule

// ----- rtl/f16fr_cfg_regs.sv -----
module f16fr_cfg_regs
    import f16fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MAGIC_WORD:  cfg_next.magic_word = cfg_data;
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word  <= 16'd0;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/f16fr_parser.sv -----
module f16fr_parser
    import f16fr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    typedef enum logic [2:0] {
        MAGIC_HI,
        MAGIC_LO,
        LEN_HI,
        LEN_LO,
        PAYLOAD,
        CHECK_HI,
        CHECK_LO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] index_reg, index_next;
    logic [7:0]  sum_low_reg, sum_low_next;
    logic [7:0]  sum_high_reg, sum_high_next;
    logic [7:0]  check_high_reg, check_high_next;
    logic [15:0] length_full;
    logic [7:0]  sum_low_upd;

    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

    assign length_full = {length_reg[15:8], rx_byte};
    assign sum_low_upd = add_mod255(sum_low_reg, rx_byte);

    always_comb begin
        phase_next      = phase_reg;
        length_next     = length_reg;
        index_next      = index_reg;
        sum_low_next    = sum_low_reg;
        sum_high_next   = sum_high_reg;
        check_high_next = check_high_reg;
        result          = '0;
        case (phase_reg)
            MAGIC_HI: begin
                phase_next = (rx_byte == cfg.magic_word[15:8]) ? MAGIC_LO : MAGIC_HI;
            end
            MAGIC_LO: begin
                phase_next = (rx_byte == cfg.magic_word[7:0]) ? LEN_HI : MAGIC_HI;
            end
            LEN_HI: begin
                length_next = {rx_byte, 8'h00};
                phase_next  = LEN_LO;
            end
            LEN_LO: begin
                length_next = length_full;
                if (length_full > cfg.max_payload) begin
                    result.event_res    = EV_TOOLONG;
                    result.frame_length = length_full;
                    phase_next          = MAGIC_HI;
                end else begin
                    sum_low_next  = 8'd0;
                    sum_high_next = 8'd0;
                    index_next    = 16'd0;
                    // an empty payload goes straight to the checksum
                    phase_next    = (length_full == 16'd0) ? CHECK_HI : PAYLOAD;
                end
            end
            PAYLOAD: begin
                sum_low_next         = sum_low_upd;
                sum_high_next        = add_mod255(sum_high_reg, sum_low_upd);
                result.event_res     = EV_DATA;
                result.data_byte     = rx_byte;
                result.payload_index = index_reg;
                result.frame_length  = length_reg;
                index_next           = index_reg + 16'd1;
                if (index_reg == length_reg - 16'd1) begin
                    phase_next = CHECK_HI;
                end
            end
            CHECK_HI: begin
                check_high_next = rx_byte;
                phase_next      = CHECK_LO;
            end
            CHECK_LO: begin
                result.event_res    = ({check_high_reg, rx_byte} == {sum_high_reg, sum_low_reg})
                                      ? EV_OK : EV_BADSUM;
                result.frame_length = length_reg;
                phase_next          = MAGIC_HI;
            end
            default: begin
                phase_next = MAGIC_HI;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MAGIC_HI;
        end else if (step) begin
            phase_reg <= phase_next;
        end
        if (step) begin
            length_reg     <= length_next;
            index_reg      <= index_next;
            sum_low_reg    <= sum_low_next;
            sum_high_reg   <= sum_high_next;
            check_high_reg <= check_high_next;
        end
    end

endmodule

// ----- rtl/f16fr_out_reg.sv -----
module f16fr_out_reg
    import f16fr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result_out
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    // take a new beat when empty or when the held one leaves this cycle
    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            result_reg <= result_in;
        end
    end

endmodule

// ----- sim/fletcher16_frame_receiver_test.sv -----
module fletcher16_frame_receiver_test;
    import f16fr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOWN_ERRORS = 10;

    localparam result_t NO_EVENT = result_t'{EV_NONE, 8'h00, 16'h0000, 16'h0000};

    typedef enum logic [1:0] {ROW_BYTE, ROW_MAGIC, ROW_LIMIT} stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        logic [15:0] val;
        bit          given;    // result typed in below, else taken from the deframer model
        result_t     res;
    } stim_row_t;

    typedef struct {
        bit      given;
        result_t res;
    } typed_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // [7:0] data_byte, [23:8] payload_index, [39:24] frame_length
    logic [2:0]  m_tuser;     // [2:0] event_res
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Register values as the block holds them
    logic [15:0] cfg_magic;
    logic [15:0] cfg_limit;

    // Deframer model state
    logic [16:0] frame_pos;
    logic [15:0] frame_len;
    logic [7:0]  fl_sum_lo;
    logic [7:0]  fl_sum_hi;
    logic [7:0]  check_hi;

    result_t       pending_results[$];
    typed_result_t typed_results[$];

    bit          steady;
    int unsigned sent_bytes;
    int unsigned mismatches;
    int unsigned reg_writes;
    int unsigned seen_data;
    int unsigned seen_ok;
    int unsigned seen_badsum;
    int unsigned seen_toolong;

    stim_row_t directed_rows [30] = '{
        // reset state: magic 0x0000, empty frame with empty sum
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, result_t'{EV_OK, 8'h00, 16'h0000, 16'h0000}},
        '{ROW_MAGIC, 16'hFF00, 1'b0, NO_EVENT},
        '{ROW_LIMIT, 16'hFFFE, 1'b0, NO_EVENT},
        // second magic byte wrong but equal to the first one: no recheck
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, result_t'{EV_TOOLONG, 8'h00, 16'h0000, 16'hFFFF}},
        '{ROW_LIMIT, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0001, 1'b1, result_t'{EV_TOOLONG, 8'h00, 16'h0000, 16'h0001}},
        '{ROW_LIMIT, 16'hFFFF, 1'b0, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0002, 1'b1, NO_EVENT},
        // magic changes in the middle of the frame
        '{ROW_MAGIC, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE,  16'h00FF, 1'b0, NO_EVENT},
        '{ROW_BYTE,  16'h0000, 1'b1, NO_EVENT},
        '{ROW_BYTE,  16'h0001, 1'b0, NO_EVENT}
    };

    fletcher16_frame_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the deframer by one received byte and return the result it reports.
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t r;
        int      pos;
        int      len;
        int      lo;
        int      hi;
        r   = NO_EVENT;
        pos = int'(frame_pos);
        len = int'(frame_len);
        if (pos == 0) begin
            frame_pos = (b == cfg_magic[15:8]) ? 17'd1 : 17'd0;
        end else if (pos == 1) begin
            frame_pos = (b == cfg_magic[7:0]) ? 17'd2 : 17'd0;
        end else if (pos == 2) begin
            frame_len = {b, 8'h00};
            frame_pos = 17'd3;
        end else if (pos == 3) begin
            frame_len[7:0] = b;
            if (frame_len > cfg_limit) begin
                r.event_res    = EV_TOOLONG;
                r.frame_length = frame_len;
                frame_pos      = 17'd0;
            end else begin
                fl_sum_lo = 8'h00;
                fl_sum_hi = 8'h00;
                frame_pos = 17'd4;
            end
        end else if (pos < 4 + len) begin
            lo              = (int'(fl_sum_lo) + int'(b)) % 255;
            hi              = (int'(fl_sum_hi) + lo) % 255;
            fl_sum_lo       = 8'(lo);
            fl_sum_hi       = 8'(hi);
            r.event_res     = EV_DATA;
            r.data_byte     = b;
            r.payload_index = 16'(pos - 4);
            r.frame_length  = frame_len;
            frame_pos       = 17'(pos + 1);
        end else if (pos == 4 + len) begin
            check_hi  = b;
            frame_pos = 17'(pos + 1);
        end else if (pos == 5 + len) begin
            r.event_res    = ({check_hi, b} == {fl_sum_hi, fl_sum_lo}) ? EV_OK : EV_BADSUM;
            r.frame_length = frame_len;
            frame_pos      = 17'd0;
        end else begin
            // position past the end of the frame: drop the byte and restart
            frame_pos = 17'd0;
        end
        return r;
    endfunction

    // Scoreboard: check result beats, then predict for accepted input beats.
    always @(posedge aclk) begin
        result_t       got;
        result_t       want;
        result_t       modeled;
        typed_result_t pin;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'{m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24]};
                case (got.event_res)
                    EV_DATA:    seen_data++;
                    EV_OK:      seen_ok++;
                    EV_BADSUM:  seen_badsum++;
                    EV_TOOLONG: seen_toolong++;
                    default:    ;
                endcase
                if (pending_results.size() == 0) begin
                    mismatches++;
                    // fields shown as event/data/index/length
                    if (mismatches <= SHOWN_ERRORS)
                        $display("%0t: unexpected beat %0d/%02h/%0d/%0d",
                                 $realtime, got.event_res, got.data_byte, got.payload_index,
                                 got.frame_length);
                end else begin
                    want = pending_results.pop_front();
                    if (got.event_res !== want.event_res || got.data_byte !== want.data_byte ||
                        got.payload_index !== want.payload_index ||
                        got.frame_length !== want.frame_length) begin
                        mismatches++;
                        // fields shown as event/data/index/length
                        if (mismatches <= SHOWN_ERRORS)
                            $display("%0t: want %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                                     $realtime, want.event_res, want.data_byte,
                                     want.payload_index, want.frame_length, got.event_res,
                                     got.data_byte, got.payload_index, got.frame_length);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pin     = typed_results.pop_front();
                modeled = deframe_byte(s_tdata);
                pending_results.push_back(pin.given ? pin.res : modeled);
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    task automatic send_byte(input logic [7:0] b, input bit given, input result_t res);
        typed_results.push_back(typed_result_t'{given, res});
        while (!steady && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
    endtask

    // Let every pending result out, then write one register.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAGIC_WORD)
            cfg_magic = val;
        else
            cfg_limit = val;
        reg_writes++;
    endtask

    task automatic send_random_frame();
        int unsigned roll;
        int unsigned len;
        int unsigned cap;
        int          lo;
        int          hi;
        logic [7:0]  b;
        logic [15:0] chk;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            // line noise
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
        end else if (roll < 20) begin
            // broken start word
            send_byte(cfg_magic[15:8], 1'b0, NO_EVENT);
            send_byte(cfg_magic[7:0] ^ 8'(1 << $urandom_range(0, 7)), 1'b0, NO_EVENT);
        end else begin
            if (roll < 32 && cfg_limit != 16'hFFFF) begin
                len = $urandom_range(int'(cfg_limit) + 1, 65535);
            end else begin
                cap = (cfg_limit < 24) ? cfg_limit : 24;
                if ($urandom_range(0, 39) == 0)
                    cap = (cfg_limit < 300) ? cfg_limit : 300;
                len = $urandom_range(0, cap);
            end
            send_byte(cfg_magic[15:8], 1'b0, NO_EVENT);
            send_byte(cfg_magic[7:0], 1'b0, NO_EVENT);
            send_byte(8'(len >> 8), 1'b0, NO_EVENT);
            send_byte(8'(len), 1'b0, NO_EVENT);
            if (len <= cfg_limit) begin
                lo = 0;
                hi = 0;
                repeat (len) begin
                    b  = 8'($urandom_range(0, 255));
                    lo = (lo + int'(b)) % 255;
                    hi = (hi + lo) % 255;
                    send_byte(b, 1'b0, NO_EVENT);
                end
                chk = {8'(hi), 8'(lo)};
                if (roll < 47)
                    chk ^= 16'($urandom_range(1, 65535));
                send_byte(chk[15:8], 1'b0, NO_EVENT);
                send_byte(chk[7:0], 1'b0, NO_EVENT);
            end
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("watchdog expired after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned phase_end;
        logic [7:0]  rep;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MAGIC_WORD;
        cfg_data     = 16'h0000;
        cfg_magic    = 16'h0000;
        cfg_limit    = MAX_PAYLOAD_RESET;
        frame_pos    = '0;
        frame_len    = '0;
        fl_sum_lo    = '0;
        fl_sum_hi    = '0;
        check_hi     = '0;
        steady       = 1'b0;
        sent_bytes   = 0;
        mismatches   = 0;
        reg_writes   = 0;
        seen_data    = 0;
        seen_ok      = 0;
        seen_badsum  = 0;
        seen_toolong = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_MAGIC: write_reg(CFG_MAGIC_WORD, directed_rows[i].val);
                ROW_LIMIT: write_reg(CFG_MAX_PAYLOAD, directed_rows[i].val);
                default:   send_byte(directed_rows[i].val[7:0], directed_rows[i].given,
                                     directed_rows[i].res);
            endcase
        end

        phase = 0;
        phase_end = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < phase_end) begin
            // a back-to-back stretch with neither side holding off
            steady = (phase == 2 || phase == 3);
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                rep = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 4))
                    0:       write_reg(CFG_MAGIC_WORD, 16'h0000);
                    1:       write_reg(CFG_MAGIC_WORD, 16'hFFFF);
                    2:       write_reg(CFG_MAGIC_WORD, {rep, rep});
                    default: write_reg(CFG_MAGIC_WORD, 16'($urandom_range(0, 65535)));
                endcase
            end
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0:       write_reg(CFG_MAX_PAYLOAD, 16'h0000);
                    1:       write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
                    2:       write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(1, 30)));
                    3:       write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(31, 400)));
                    default: write_reg(CFG_MAX_PAYLOAD, 16'($urandom_range(0, 65535)));
                endcase
            end
            repeat ($urandom_range(12, 30)) begin
                if (sent_bytes < phase_end)
                    send_random_frame();
            end
            phase++;
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes over %0d register settings (%0d writes).",
                 sent_bytes, phase + 4, reg_writes);
        $display("Frames: %0d accepted, %0d bad checksum, %0d oversize; %0d payload bytes.",
                 seen_ok, seen_badsum, seen_toolong, seen_data);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatched result beats", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/f16fr_pkg.sv
rtl/f16fr_cfg_regs.sv
rtl/f16fr_parser.sv
rtl/f16fr_out_reg.sv
rtl/fletcher16_frame_receiver.sv
sim/fletcher16_frame_receiver_test.sv
